### rtl/pgt_pkg.sv
// ---------------------------------------------------------------------------
// pgt_pkg: shared types and constants for the piece gap tracker
// Request and result payloads, status codes, register indexes, and the
// command/status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package pgt_pkg;

  // Field widths
  localparam int PIECE_W   = 32;
  localparam int LEN_W     = 17;
  localparam int TOTAL_W   = 32;
  localparam int PBYTES_W  = 17;
  localparam int STATUS_W  = 3;
  localparam int OFFSET_W  = 32;
  localparam int FFIRST_W  = 16;
  localparam int FCOUNT_W  = 11;
  localparam int ACCEPT_W  = 32;
  localparam int MISSING_W = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // Bitmap word organization
  localparam int MAP_WORD_W = 32;
  localparam int MAP_BIT_W  = 5;

  // Reset value of the nominal piece size
  localparam logic [PBYTES_W-1:0] PIECE_BYTES_RST = 17'd1024;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GAP       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GAP_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISHED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERRUN   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd6;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_BYTES = 1'b0,
    REG_PIECE_BYTES = 1'b1
  } cfg_reg_t;

  typedef logic [MAP_WORD_W-1:0] map_word_t;
  typedef logic [MAP_BIT_W-1:0]  map_bit_t;

  typedef struct packed {
    logic [PIECE_W-1:0] piece_index;
    logic [LEN_W-1:0]   data_bytes;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 write_enable;
    logic [OFFSET_W-1:0]  write_offset;
    logic [FFIRST_W-1:0]  fill_first;
    logic [FCOUNT_W-1:0]  fill_count;
    logic [ACCEPT_W-1:0]  accepted_bytes;
    logic [MISSING_W-1:0] missing_total;
  } out_item_t;

  // Controller state
  typedef enum logic [1:0] {
    S_IDLE,
    S_CLASSIFY,
    S_MARK
  } state_t;

  // Datapath operation for the current cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLOSED,
    OP_RANGE,
    OP_LARGE,
    OP_INORDER,
    OP_LATE,
    OP_MARK
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic closed;
    logic in_range;
    logic ahead;
    logic behind;
    logic gap_large;
    logic mark_last;
  } dp_status_t;

endpackage

### rtl/piece_gap_tracker.sv
// Results: in-order, late, closed, out-of-range and oversize-gap requests
// are answered once classified; a gap is answered after the bitmap is marked
// word by word over the 32-bit words spanned from next expected to the piece.
// A new request is taken only while idle, after the bitmap read-then-write
// of the one before; gaps mark one word per cycle.
// Reset clears all tracking state; the bitmap needs no clearing pass.
// ---------------------------------------------------------------------------
// piece_gap_tracker: receive-side gap tracker for a selective-repeat transfer
// Classifies each received piece, marks and refills missing pieces, and
// reports write decisions, zero-fill ranges and finish or overrun.
// ---------------------------------------------------------------------------
module piece_gap_tracker #(
  parameter int MAX_PIECES = 65536,
  parameter int MAX_GAP    = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  pgt_pkg::in_item_t               in_item,
  output logic                            out_valid,
  output pgt_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pgt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pgt_pkg::dp_cmd_t    dp_cmd;
  pgt_pkg::dp_status_t dp_status;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  pgt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  pgt_datapath #(
    .MAX_PIECES (MAX_PIECES),
    .MAX_GAP    (MAX_GAP)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### rtl/pgt_ctrl.sv
// ---------------------------------------------------------------------------
// pgt_ctrl: request sequencing for the piece gap tracker
// Accepts a request, classifies it from datapath status and steps the
// bitmap marking of a gap one word per cycle.
// ---------------------------------------------------------------------------
module pgt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pgt_pkg::dp_status_t dp_status,
  output pgt_pkg::dp_cmd_t    dp_cmd
);

  pgt_pkg::state_t state_r, state_nxt;

  // Gap that still spans more than the current word
  logic mark_more;
  assign mark_more = !dp_status.closed && dp_status.in_range && dp_status.ahead &&
                     !dp_status.gap_large && !dp_status.mark_last;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pgt_pkg::S_IDLE: begin
        if (start) state_nxt = pgt_pkg::S_CLASSIFY;
      end
      pgt_pkg::S_CLASSIFY: begin
        state_nxt = mark_more ? pgt_pkg::S_MARK : pgt_pkg::S_IDLE;
      end
      pgt_pkg::S_MARK: begin
        if (dp_status.mark_last) state_nxt = pgt_pkg::S_IDLE;
      end
      default: state_nxt = pgt_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    dp_cmd.load = 1'b0;
    dp_cmd.op   = pgt_pkg::OP_NONE;
    busy        = 1'b1;
    unique case (state_r)
      pgt_pkg::S_IDLE: begin
        busy        = 1'b0;
        dp_cmd.load = start;
      end
      pgt_pkg::S_CLASSIFY: begin
        if (dp_status.closed)          dp_cmd.op = pgt_pkg::OP_CLOSED;
        else if (!dp_status.in_range)  dp_cmd.op = pgt_pkg::OP_RANGE;
        else if (dp_status.ahead) begin
          dp_cmd.op = dp_status.gap_large ? pgt_pkg::OP_LARGE : pgt_pkg::OP_MARK;
        end
        else if (dp_status.behind)     dp_cmd.op = pgt_pkg::OP_LATE;
        else                           dp_cmd.op = pgt_pkg::OP_INORDER;
      end
      pgt_pkg::S_MARK: begin
        dp_cmd.op = pgt_pkg::OP_MARK;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

### rtl/pgt_datapath.sv
// ---------------------------------------------------------------------------
// pgt_datapath: tracker state, missing-piece bitmap and result register
// Holds next expected piece, byte and missing counts, the closed flag, the
// configuration registers and a 32-bit-word bitmap with bit write enables.
// ---------------------------------------------------------------------------
module pgt_datapath #(
  parameter int MAX_PIECES = 65536,
  parameter int MAX_GAP    = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pgt_pkg::dp_cmd_t                    dp_cmd,
  output pgt_pkg::dp_status_t                 dp_status,
  input  pgt_pkg::in_item_t                   in_item,
  input  logic                                cfg_wr,
  input  logic [pgt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  output pgt_pkg::out_item_t                  out_item
);

  localparam int PW        = $clog2(MAX_PIECES);
  localparam int NE_W      = $clog2(MAX_PIECES + 1);
  localparam int PROD_W    = PW + pgt_pkg::PBYTES_W;
  localparam int MAP_DEPTH = (MAX_PIECES + pgt_pkg::MAP_WORD_W - 1) / pgt_pkg::MAP_WORD_W;
  localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  typedef logic [NE_W-1:0]   ne_t;
  typedef logic [PW-1:0]     pidx_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Configuration
  logic [pgt_pkg::TOTAL_W-1:0]  total_r;
  logic [pgt_pkg::PBYTES_W-1:0] pbytes_r;

  // Request and tracker state
  logic [pgt_pkg::PIECE_W-1:0]  piece_r;
  logic [pgt_pkg::LEN_W-1:0]    len_r;
  logic [pgt_pkg::OFFSET_W-1:0] prod_r;
  pgt_pkg::map_word_t           rdata_r;
  ne_t                          cursor_r, cursor_nxt;
  ne_t                          ne_r, ne_nxt;
  ne_t                          cnt_r, cnt_nxt;
  logic [pgt_pkg::ACCEPT_W-1:0] bytes_r, bytes_nxt;
  logic                         closed_r, closed_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pgt_pkg::out_item_t           out_item_r, out_item_nxt;

  // Bitmap
  pgt_pkg::map_word_t mem [MAP_DEPTH];
  logic               wr_en;
  addr_t              wr_addr;
  pgt_pkg::map_word_t wr_mask;
  pgt_pkg::map_word_t wr_data;

  // Derived request values
  ne_t                p_ne;
  pgt_pkg::map_bit_t  p_bit;
  pgt_pkg::map_bit_t  cur_bit;
  ne_t                gap;
  ne_t                cur_next;
  logic [pgt_pkg::ACCEPT_W:0] bytes_sum;
  logic [pgt_pkg::ACCEPT_W-1:0] bytes_add;
  prod_t              prod_full;

  assign p_ne      = ne_t'(piece_r);
  assign p_bit     = pgt_pkg::map_bit_t'(piece_r);
  assign cur_bit   = pgt_pkg::map_bit_t'(cursor_r);
  assign gap       = p_ne - ne_r;
  assign cur_next  = (cursor_r & ~ne_t'(pgt_pkg::MAP_WORD_W - 1)) + ne_t'(pgt_pkg::MAP_WORD_W);
  assign bytes_sum = {1'b0, bytes_r} + (pgt_pkg::ACCEPT_W + 1)'(len_r);
  assign bytes_add = bytes_sum[pgt_pkg::ACCEPT_W] ? '1 : bytes_sum[pgt_pkg::ACCEPT_W-1:0];
  assign prod_full = prod_t'(pidx_t'(in_item.piece_index)) * prod_t'(pbytes_r);

  // Status toward the controller
  assign dp_status.closed    = closed_r;
  assign dp_status.in_range  = piece_r < pgt_pkg::PIECE_W'(MAX_PIECES);
  assign dp_status.ahead     = p_ne > ne_r;
  assign dp_status.behind    = p_ne < ne_r;
  assign dp_status.gap_large = 32'(gap) > 32'(MAX_GAP);
  assign dp_status.mark_last = (cursor_r >> pgt_pkg::MAP_BIT_W) == (p_ne >> pgt_pkg::MAP_BIT_W);

  // Request capture, offset product and bitmap read
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      piece_r  <= in_item.piece_index;
      len_r    <= in_item.data_bytes;
      prod_r   <= pgt_pkg::OFFSET_W'(prod_full);
      cursor_r <= ne_r;
      rdata_r  <= mem[addr_t'(pidx_t'(in_item.piece_index) >> pgt_pkg::MAP_BIT_W)];
    end else begin
      cursor_r <= cursor_nxt;
    end
  end

  // Bitmap write with per-bit enables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < pgt_pkg::MAP_WORD_W; b++) begin
        if (wr_mask[b]) mem[wr_addr][b] <= wr_data[b];
      end
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      pbytes_r    <= pgt_pkg::PIECE_BYTES_RST;
      ne_r        <= '0;
      cnt_r       <= '0;
      bytes_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ne_r        <= ne_nxt;
      cnt_r       <= cnt_nxt;
      bytes_r     <= bytes_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (pgt_pkg::cfg_reg_t'(cfg_index))
          pgt_pkg::REG_TOTAL_BYTES: total_r  <= cfg_data;
          pgt_pkg::REG_PIECE_BYTES: pbytes_r <= pgt_pkg::PBYTES_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_valid_nxt) out_item_r <= out_item_nxt;
  end

  // Per-operation update and result
  always_comb begin
    logic we;
    logic check;
    logic [pgt_pkg::STATUS_W-1:0] st;

    we            = 1'b0;
    check         = 1'b0;
    st            = pgt_pkg::ST_OK;
    cursor_nxt    = cursor_r;
    ne_nxt        = ne_r;
    cnt_nxt       = cnt_r;
    bytes_nxt     = bytes_r;
    closed_nxt    = closed_r;
    out_valid_nxt = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = addr_t'(p_ne >> pgt_pkg::MAP_BIT_W);
    wr_mask       = '0;
    wr_data       = '0;
    out_item_nxt.fill_first = '0;
    out_item_nxt.fill_count = '0;

    case (dp_cmd.op)
      pgt_pkg::OP_CLOSED: begin
        out_valid_nxt = 1'b1;
        st            = pgt_pkg::ST_CLOSED;
      end
      pgt_pkg::OP_RANGE: begin
        out_valid_nxt = 1'b1;
        st            = pgt_pkg::ST_RANGE;
      end
      pgt_pkg::OP_LARGE: begin
        out_valid_nxt = 1'b1;
        st            = pgt_pkg::ST_GAP_LARGE;
      end
      pgt_pkg::OP_INORDER: begin
        // in-order piece: its own bit is written clear
        out_valid_nxt   = 1'b1;
        check           = 1'b1;
        we              = 1'b1;
        bytes_nxt       = bytes_add;
        ne_nxt          = p_ne + ne_t'(1);
        wr_en           = 1'b1;
        wr_mask[p_bit]  = 1'b1;
      end
      pgt_pkg::OP_LATE: begin
        out_valid_nxt = 1'b1;
        check         = 1'b1;
        if (rdata_r[p_bit]) begin
          we             = 1'b1;
          bytes_nxt      = bytes_add;
          if (cnt_r != '0) cnt_nxt = cnt_r - ne_t'(1);
          wr_en          = 1'b1;
          wr_mask[p_bit] = 1'b1;
        end
      end
      pgt_pkg::OP_MARK: begin
        // set missing bits from cursor up to the piece, clear the piece itself
        wr_en   = 1'b1;
        wr_addr = addr_t'(cursor_r >> pgt_pkg::MAP_BIT_W);
        for (int b = 0; b < pgt_pkg::MAP_WORD_W; b++) begin
          wr_mask[b] = (pgt_pkg::map_bit_t'(b) >= cur_bit) &&
                       (!dp_status.mark_last || pgt_pkg::map_bit_t'(b) <= p_bit);
          wr_data[b] = !(dp_status.mark_last && pgt_pkg::map_bit_t'(b) == p_bit);
        end
        if (dp_status.mark_last) begin
          out_valid_nxt = 1'b1;
          check         = 1'b1;
          we            = 1'b1;
          st            = pgt_pkg::ST_GAP;
          bytes_nxt     = bytes_add;
          ne_nxt        = p_ne + ne_t'(1);
          cnt_nxt       = cnt_r + gap;
          out_item_nxt.fill_first = pgt_pkg::FFIRST_W'(ne_r);
          out_item_nxt.fill_count = pgt_pkg::FCOUNT_W'(gap);
        end else begin
          cursor_nxt = cur_next;
        end
      end
      default: ;
    endcase

    // Finish check against the total size
    if (check) begin
      if (bytes_nxt == total_r) begin
        st         = pgt_pkg::ST_FINISHED;
        closed_nxt = 1'b1;
      end else if (bytes_nxt > total_r) begin
        st = pgt_pkg::ST_OVERRUN;
      end
    end

    out_item_nxt.status         = st;
    out_item_nxt.write_enable   = we;
    out_item_nxt.write_offset   = we ? prod_r : '0;
    out_item_nxt.accepted_bytes = bytes_nxt;
    out_item_nxt.missing_total  = pgt_pkg::MISSING_W'(cnt_nxt);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Once closed, the tracker stays closed
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("closed flag cleared");

  // Missing pieces all lie below the next expected piece
  a_missing_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ne_r)
    else $error("missing count above next expected");

  // Marking never runs past the received piece
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == pgt_pkg::OP_MARK) |-> (cursor_r <= p_ne))
    else $error("gap cursor past piece");

  // A result strobe follows an operation that ends a request
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(dp_cmd.op != pgt_pkg::OP_NONE))
    else $error("result without request");

endmodule
